@@ hdl/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, constants and helpers for the height-field bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int IDX_BITS    = $clog2(MAX_SIDE);
	localparam int ADDR_BITS   = 2 * IDX_BITS;
	localparam int SIDE_BITS   = 9;
	localparam int HEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int COORD_BITS  = 17;
	localparam int POS_BITS    = IDX_BITS + FRAC_BITS;
	localparam int WT_BITS     = FRAC_BITS + 1;
	localparam int WPROD_BITS  = 2 * WT_BITS;
	localparam int ACC_BITS    = HEIGHT_BITS + WPROD_BITS;
	localparam int OUT_BITS    = 24;

	// Input tdata layout, lowest field first.
	localparam int TD_COL_LSB    = 0;
	localparam int TD_ROW_LSB    = TD_COL_LSB + IDX_BITS;
	localparam int TD_HEIGHT_LSB = TD_ROW_LSB + IDX_BITS;
	localparam int TD_X_LSB      = TD_HEIGHT_LSB + HEIGHT_BITS;
	localparam int TD_Y_LSB      = TD_X_LSB + COORD_BITS;
	localparam int TD_IN_USED    = TD_Y_LSB + COORD_BITS;
	localparam int S_TDATA_BITS  = ((TD_IN_USED + 7) / 8) * 8;
	localparam int M_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

	// Item kinds carried on the input tuser.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [SIDE_BITS-1:0] SIDE_MIN   = SIDE_BITS'(2);
	localparam logic [SIDE_BITS-1:0] SIDE_MAX   = SIDE_BITS'(MAX_SIDE);
	localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(256);
	localparam logic [WT_BITS-1:0]   WT_ONE     = WT_BITS'(1 << FRAC_BITS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       clr_en;
		logic       start;
		logic       wr_en;
		logic       rd_en;
		logic [1:0] rd_idx;
		logic       ld_out;
	} hbs_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} hbs_status_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] base;
		logic [WT_BITS-1:0]  frac;
	} axis_split_t;

	// Clamp one coordinate to [0, side-1], take its cell index capped at
	// side-2, and return the fraction left over (which reaches one at the
	// far edge).
	function automatic axis_split_t axis_split(
		input logic signed [COORD_BITS-1:0] coord,
		input logic [IDX_BITS-1:0]          side_m1
	);
		logic [POS_BITS-1:0] hi;
		logic [POS_BITS-1:0] pos;
		logic [IDX_BITS-1:0] cap;
		logic [IDX_BITS-1:0] base;
		logic [POS_BITS-1:0] diff;
		axis_split_t         res;
		hi  = {side_m1, {FRAC_BITS{1'b0}}};
		cap = side_m1 - IDX_BITS'(1);
		if (coord[COORD_BITS-1]) begin
			pos = '0;
		end else if (coord[POS_BITS-1:0] > hi) begin
			pos = hi;
		end else begin
			pos = coord[POS_BITS-1:0];
		end
		base = pos[POS_BITS-1:FRAC_BITS];
		if (base > cap) begin
			base = cap;
		end
		diff = pos - {base, {FRAC_BITS{1'b0}}};
		res.base = base;
		res.frac = diff[WT_BITS-1:0];
		return res;
	endfunction

endpackage

@@ hdl/hbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbs_ctrl
// Sequencer: clearing pass, request intake, four corner reads and result load.
// ----------------------------------------------------------------------------
module hbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  hbs_pkg::hbs_status_t status,
	output hbs_pkg::hbs_cmd_t    cmd
);
	import hbs_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] cnt_q;
	logic       accept;

	assign accept = s_tvalid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ || state_q == ST_DRAIN) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == CMD_SAMPLE) ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				if (cnt_q == 2'd3) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (cnt_q == 2'd1) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.clr_en = (state_q == ST_CLEAR);
		cmd.start  = accept;
		cmd.wr_en  = accept && (s_tuser == CMD_WRITE);
		cmd.rd_en  = (state_q == ST_READ);
		cmd.rd_idx = cnt_q;
		cmd.ld_out = (state_q == ST_FINISH) && status.out_free;
	end

endmodule

@@ hdl/hbs_datapath.sv @@
// ----------------------------------------------------------------------------
// hbs_datapath
// Height store, coordinate split, weighted corner accumulation, result register.
// ----------------------------------------------------------------------------
module hbs_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [hbs_pkg::SIDE_BITS-1:0]          cfg_wdata,
	input  logic                                   s_tuser,
	input  logic [hbs_pkg::S_TDATA_BITS-1:0]       s_tdata,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic                                   m_tuser,
	output logic [hbs_pkg::M_TDATA_BITS-1:0]       m_tdata,
	input  hbs_pkg::hbs_cmd_t                      cmd,
	output hbs_pkg::hbs_status_t                   status
);
	import hbs_pkg::*;

	logic signed [HEIGHT_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

	logic [SIDE_BITS-1:0]          grid_side_q;
	logic [SIDE_BITS-1:0]          side_eff;
	logic [IDX_BITS-1:0]           side_m1;
	logic [ADDR_BITS-1:0]          clr_addr_q;

	logic [IDX_BITS-1:0]           in_col;
	logic [IDX_BITS-1:0]           in_row;
	logic signed [HEIGHT_BITS-1:0] in_height;
	logic signed [COORD_BITS-1:0]  in_x;
	logic signed [COORD_BITS-1:0]  in_y;
	axis_split_t                   split_x;
	axis_split_t                   split_y;

	logic [IDX_BITS-1:0]           x0_q;
	logic [IDX_BITS-1:0]           y0_q;
	logic [WT_BITS-1:0]            fx_q;
	logic [WT_BITS-1:0]            fy_q;
	logic                          kind_q;

	logic                          mem_we;
	logic [ADDR_BITS-1:0]          mem_waddr;
	logic signed [HEIGHT_BITS-1:0] mem_wdata;
	logic [IDX_BITS-1:0]           rd_col;
	logic [IDX_BITS-1:0]           rd_row;
	logic [WT_BITS-1:0]            wx;
	logic [WT_BITS-1:0]            wy;
	logic [WPROD_BITS-1:0]         wt;

	logic signed [HEIGHT_BITS-1:0] rdata_s1;
	logic [WPROD_BITS-1:0]         wt_s1;
	logic                          v_s1;
	logic signed [ACC_BITS-1:0]    prod;
	logic signed [ACC_BITS-1:0]    prod_s2;
	logic                          v_s2;
	logic signed [ACC_BITS-1:0]    acc_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [OUT_BITS-1:0]           out_data_q;

	assign in_col    = s_tdata[TD_COL_LSB +: IDX_BITS];
	assign in_row    = s_tdata[TD_ROW_LSB +: IDX_BITS];
	assign in_height = s_tdata[TD_HEIGHT_LSB +: HEIGHT_BITS];
	assign in_x      = s_tdata[TD_X_LSB +: COORD_BITS];
	assign in_y      = s_tdata[TD_Y_LSB +: COORD_BITS];

	// Side values 0 and 1 behave as 2; anything above the store acts as full size.
	always_comb begin
		if (grid_side_q < SIDE_MIN) begin
			side_eff = SIDE_MIN;
		end else if (grid_side_q > SIDE_MAX) begin
			side_eff = SIDE_MAX;
		end else begin
			side_eff = grid_side_q;
		end
	end

	assign side_m1 = IDX_BITS'(side_eff - SIDE_BITS'(1));
	assign split_x = axis_split(in_x, side_m1);
	assign split_y = axis_split(in_y, side_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
			clr_addr_q  <= '0;
		end else begin
			if (cfg_we) grid_side_q <= cfg_wdata;
			if (cmd.clr_en) clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
		end
	end

	assign status.clr_last = &clr_addr_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x0_q   <= split_x.base;
			y0_q   <= split_y.base;
			fx_q   <= split_x.frac;
			fy_q   <= split_y.frac;
			kind_q <= s_tuser;
		end
	end

	always_comb begin
		if (cmd.clr_en) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = cmd.wr_en;
			mem_waddr = {in_row, in_col};
			mem_wdata = in_height;
		end
	end

	// Corner order: bit 0 of the index steps the column, bit 1 the row.
	assign rd_col = x0_q + IDX_BITS'(cmd.rd_idx[0]);
	assign rd_row = y0_q + IDX_BITS'(cmd.rd_idx[1]);
	assign wx     = cmd.rd_idx[0] ? fx_q : WT_ONE - fx_q;
	assign wy     = cmd.rd_idx[1] ? fy_q : WT_ONE - fy_q;
	assign wt     = wx * wy;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_s1 <= mem[{rd_row, rd_col}];
		wt_s1    <= wt;
	end

	assign prod = ACC_BITS'($signed(rdata_s1)) * ACC_BITS'($signed({1'b0, wt_s1}));

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The blend of four heights stays within the height range scaled by one,
	// so the floor of the sum always fits the result width.
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_kind_q <= kind_q;
			out_data_q <= (kind_q == CMD_SAMPLE) ? acc_q[FRAC_BITS +: OUT_BITS] : '0;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tuser         = out_kind_q;
	assign m_tdata         = M_TDATA_BITS'(out_data_q);

endmodule

@@ hdl/heightfield_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Square grid of signed heights with write and bilinear sample requests.
// ----------------------------------------------------------------------------
// After reset the block first zeroes its 256 x 256 height store, one entry
// per cycle; s_tready stays low during that pass while cfg_we writes are
// still taken. A write request (tuser 0) stores one height and is answered
// with an acknowledgement (m_tuser 0, data 0). A sample request (tuser 1)
// clamps its coordinates to the side in use, reads the four corner heights
// one per cycle through the single read port of the store, and returns the
// blended height. The next request is taken as soon as the result sits in
// the output register.
module heightfield_bilinear_sampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hbs_pkg::SIDE_BITS-1:0]     cfg_wdata,    // grid_side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: cell_col[7:0], cell_row[15:8], height_value[31:16],
	// sample_x[48:32], sample_y[65:49], zero fill above
	input  logic [hbs_pkg::S_TDATA_BITS-1:0]  s_tdata,
	input  logic                              s_tuser,      // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hbs_pkg::M_TDATA_BITS-1:0]  m_tdata,      // sampled_height[23:0]
	output logic                              m_tuser       // is_sample
);
	import hbs_pkg::*;

	hbs_cmd_t    cmd;
	hbs_status_t status;

	hbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hbs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

@@ bench/tb_heightfield_bilinear_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightfield_bilinear_sampler
// Streams write and sample requests into the height-field sampler under
// random flow control, predicts every answer from a shadow copy of the
// height grid and the side setting, and compares each result in order.
// ----------------------------------------------------------------------------
module tb_heightfield_bilinear_sampler;
	import hbs_pkg::*;

	localparam int     CLK_PERIOD  = 10;
	localparam int     CYCLE_LIMIT = 1_000_000;
	localparam longint ONE         = longint'(1) << FRAC_BITS;
	localparam longint OUT_HI      = (longint'(1) << (OUT_BITS - 1)) - 1;
	localparam longint OUT_LO      = -(longint'(1) << (OUT_BITS - 1));

	typedef struct {
		logic                          cmd;
		logic [IDX_BITS-1:0]           col;
		logic [IDX_BITS-1:0]           row;
		logic signed [HEIGHT_BITS-1:0] height;
		logic signed [COORD_BITS-1:0]  sx;
		logic signed [COORD_BITS-1:0]  sy;
	} grid_req_t;

	typedef struct {
		logic                       is_sample;
		logic signed [OUT_BITS-1:0] height;
	} height_ans_t;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [SIDE_BITS-1:0]    cfg_wdata = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata   = '0;
	logic                    s_tuser   = CMD_WRITE;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic                    m_tuser;

	heightfield_bilinear_sampler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow state of the block.
	logic signed [HEIGHT_BITS-1:0] shadow_heights [MAX_SIDE * MAX_SIDE];
	int                            shadow_side;

	grid_req_t   pending_reqs [$];
	height_ans_t answers_due  [$];
	int          queued_total   = 0;
	int          accepted_total = 0;
	int          results_seen   = 0;
	int          mismatches     = 0;
	int          cycle_count    = 0;
	int          recent_col     = 0;
	int          recent_row     = 0;

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch on result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
	endtask

	function automatic longint pin(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int side_in_use(input int side);
		return int'(pin(side, 2, MAX_SIDE));
	endfunction

	function automatic longint height_at(input longint c, input longint r);
		return longint'(shadow_heights[r * MAX_SIDE + c]);
	endfunction

	// Applies one accepted request to the shadow grid and returns its answer.
	function automatic height_ans_t sampler_answer(input grid_req_t r);
		height_ans_t ans;
		longint      eff, lim, x, y, x0, y0, fx, fy, top, bot, acc;
		ans.is_sample = (r.cmd == CMD_SAMPLE);
		ans.height    = '0;
		if (r.cmd == CMD_WRITE) begin
			shadow_heights[{r.row, r.col}] = r.height;
			return ans;
		end
		eff = side_in_use(shadow_side);
		lim = (eff - 1) * ONE;
		x   = pin(longint'(r.sx), 0, lim);
		y   = pin(longint'(r.sy), 0, lim);
		x0  = pin(x / ONE, 0, eff - 2);
		y0  = pin(y / ONE, 0, eff - 2);
		// The fraction reaches one whole cell at the far edge.
		fx  = x - x0 * ONE;
		fy  = y - y0 * ONE;
		top = height_at(x0, y0) * (ONE - fx) + height_at(x0 + 1, y0) * fx;
		bot = height_at(x0, y0 + 1) * (ONE - fx) + height_at(x0 + 1, y0 + 1) * fx;
		acc = top * (ONE - fy) + bot * fy;
		ans.height = OUT_BITS'(pin(acc >>> FRAC_BITS, OUT_LO, OUT_HI));
		return ans;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	grid_req_t offer;
	int        burst_left = 0;
	int        gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_WRITE;
		end else begin
			if (s_tvalid && s_tready) begin
				answers_due.push_back(sampler_answer(offer));
				accepted_total++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					offer = pending_reqs.pop_front();
					s_tdata  <= S_TDATA_BITS'({offer.sy, offer.sx, offer.height,
						offer.row, offer.col});
					s_tuser  <= offer.cmd;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks results in order and stalls on a changing pattern.
	ready_mode_t ready_mode   = RDY_ALWAYS;
	int          pattern_left = 0;
	int          hold_left    = 0;

	always @(posedge clk or negedge arst_n) begin
		height_ans_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (answers_due.size() == 0) begin
					flag_mismatch("result with no request pending",
						$signed(m_tdata[OUT_BITS-1:0]), 0);
				end else begin
					want = answers_due.pop_front();
					if (m_tuser !== want.is_sample) begin
						flag_mismatch("is_sample", m_tuser, want.is_sample);
					end
					if ($signed(m_tdata[OUT_BITS-1:0]) !== want.height) begin
						flag_mismatch("sampled_height", $signed(m_tdata[OUT_BITS-1:0]),
							want.height);
					end
				end
				// Long back-pressure so that the block fills up and stalls its input.
				if (results_seen == 400 || results_seen == 1000) begin
					hold_left = 500;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					ready_mode   = ready_mode_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(10, 80);
				end
				pattern_left--;
				case (ready_mode)
					RDY_ALWAYS: m_tready <= 1'b1;
					RDY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
					RDY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
					default:    m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_request(input grid_req_t r);
		pending_reqs.push_back(r);
		queued_total++;
	endtask

	task automatic push_write(input int col, input int row, input int h);
		grid_req_t r;
		r.cmd    = CMD_WRITE;
		r.col    = IDX_BITS'(col);
		r.row    = IDX_BITS'(row);
		r.height = HEIGHT_BITS'(h);
		r.sx     = COORD_BITS'($urandom);
		r.sy     = COORD_BITS'($urandom);
		push_request(r);
	endtask

	task automatic push_sample(input int x, input int y);
		grid_req_t r;
		r.cmd    = CMD_SAMPLE;
		r.col    = IDX_BITS'($urandom);
		r.row    = IDX_BITS'($urandom);
		r.height = HEIGHT_BITS'($urandom);
		r.sx     = COORD_BITS'(x);
		r.sy     = COORD_BITS'(y);
		push_request(r);
	endtask

	// Mostly inside the grid, some near the last written cell or the far
	// edge, and a few anywhere in the field's range.
	function automatic logic signed [COORD_BITS-1:0] coord_pick(input int eff, input int near);
		int v;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: v = int'($urandom_range(0, (eff - 1) * ONE));
			4, 5:       v = near * int'(ONE) + int'($urandom_range(0, 511)) - 256;
			6:          v = (eff - 1) * int'(ONE) + int'($urandom_range(0, 512)) - 256;
			default:    v = int'($urandom_range(0, 131071)) - 65536;
		endcase
		if (v > 65535) begin
			v = 65535;
		end
		return COORD_BITS'(v);
	endfunction

	task automatic random_phase(input int n);
		grid_req_t r;
		int        eff;
		int        pick;
		eff = side_in_use(shadow_side);
		repeat (n) begin
			r.cmd    = CMD_SAMPLE;
			r.col    = IDX_BITS'($urandom);
			r.row    = IDX_BITS'($urandom);
			r.height = HEIGHT_BITS'($urandom);
			r.sx     = COORD_BITS'($urandom);
			r.sy     = COORD_BITS'($urandom);
			pick     = $urandom_range(0, 9);
			if (pick < 4) begin
				r.cmd = CMD_WRITE;
				if (pick == 1 || pick == 2) begin
					// Cluster writes so that samples find nonzero corners.
					r.col = IDX_BITS'((recent_col + $urandom_range(0, 2)) % eff);
					r.row = IDX_BITS'((recent_row + $urandom_range(0, 2)) % eff);
				end else if (pick == 0) begin
					r.col = IDX_BITS'($urandom_range(0, eff - 1));
					r.row = IDX_BITS'($urandom_range(0, eff - 1));
				end
				if ($urandom_range(0, 6) == 0) begin
					r.height = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				end
				recent_col = r.col;
				recent_row = r.row;
			end else if (pick < 9) begin
				r.sx = coord_pick(eff, recent_col);
				r.sy = coord_pick(eff, recent_row);
			end else begin
				r.cmd = ($urandom_range(0, 1) == 1) ? CMD_SAMPLE : CMD_WRITE;
			end
			push_request(r);
		end
	endtask

	task automatic drain_all();
		do begin
			@(negedge clk);
		end while (accepted_total != queued_total || results_seen != accepted_total);
	endtask

	task automatic set_side(input int v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= SIDE_BITS'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_side = v & ((1 << SIDE_BITS) - 1);
		@(negedge clk);
	endtask

	initial begin
		int phase_sides [12];
		phase_sides = '{2, 3, 7, 16, 0, 256, 511, 1, 33, 0, 128, 5};
		foreach (shadow_heights[i]) begin
			shadow_heights[i] = '0;
		end
		shadow_side = SIDE_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// Taken while the store is still being cleared.
		set_side(4);

		// Full-scale corners: a flat positive patch and a flat negative patch.
		push_write(0, 0, 32767);
		push_write(1, 0, 32767);
		push_write(0, 1, 32767);
		push_write(1, 1, 32767);
		push_sample(128, 128);
		push_write(2, 2, -32768);
		push_write(3, 2, -32768);
		push_write(2, 3, -32768);
		push_write(3, 3, -32768);
		push_sample(65535, 65535);
		push_sample(-65536, -65536);
		push_sample(-1, 767);
		push_sample(384, 255);
		// Stored outside the side in use; must not show until the side grows.
		push_write(255, 255, -1);
		push_write(200, 3, 1234);
		push_sample(767, 0);
		push_write(1, 0, -32768);
		push_sample(1, 1);
		push_sample(255, 640);
		drain_all();

		set_side(256);
		push_sample(255 * 256, 255 * 256);
		push_sample(65535, 65535);
		push_sample(200 * 256 + 17, 3 * 256 + 200);
		push_write(0, 255, 21845);
		push_sample(-300, 65535);
		drain_all();

		foreach (phase_sides[p]) begin
			set_side(p == 9 ? $urandom_range(2, 300) : phase_sides[p]);
			random_phase(120);
			drain_all();
		end

		repeat (20) @(posedge clk);
		if (answers_due.size() != 0) begin
			flag_mismatch("results never returned", answers_due.size(), 0);
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
